### rtl/pwt_pkg.sv
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types, register indexes, reset values and the CORDIC arctangent
// table for the pixel to world transform.
// ----------------------------------------------------------------------------
package pwt_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_MAX     = 24;
    localparam int CORDIC_W       = 34;
    localparam int CFG_INDEX_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MPP          = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd3;

    localparam logic [15:0] MPP_RESET    = 16'd328;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [31:0] NEG_ONE_Q30 = -32'sd1073741824;

    typedef struct packed {
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } trig_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input int i);
        logic [29:0] r;
        case (i)
            0:       r = 30'd536870912;
            1:       r = 30'd316933405;
            2:       r = 30'd167458907;
            3:       r = 30'd85004756;
            4:       r = 30'd42667331;
            5:       r = 30'd21354465;
            6:       r = 30'd10679838;
            7:       r = 30'd5340245;
            8:       r = 30'd2670163;
            9:       r = 30'd1335086;
            10:      r = 30'd667544;
            11:      r = 30'd333772;
            12:      r = 30'd166886;
            13:      r = 30'd83443;
            14:      r = 30'd41721;
            15:      r = 30'd20860;
            16:      r = 30'd10430;
            17:      r = 30'd5215;
            18:      r = 30'd2607;
            19:      r = 30'd1303;
            20:      r = 30'd651;
            21:      r = 30'd325;
            22:      r = 30'd162;
            23:      r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/pwt_cordic.sv
// ----------------------------------------------------------------------------
// pwt_cordic
// Pipelined rotation-mode CORDIC: one micro-rotation per stage, half-turn
// fold ahead of the array, sign restore and unit clamp at the end.
// The angle is registered ahead of the array and the clamped result behind it.
// ----------------------------------------------------------------------------
module pwt_cordic #(
    parameter int ITER = pwt_pkg::ANGLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          adv,
    input  logic [15:0]   yaw,
    output pwt_pkg::trig_t trig
);

    localparam int N = (ITER < pwt_pkg::CORDIC_MAX) ? ITER : pwt_pkg::CORDIC_MAX;
    localparam int W = pwt_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] z_reg [0:N];
    logic                flip_reg [0:N];
    pwt_pkg::trig_t      trig_reg;
    pwt_pkg::trig_t      trig_next;

    logic                flip_in;
    logic [15:0]         phase_in;
    logic signed [W-1:0] x_fin;
    logic signed [W-1:0] y_fin;

    assign flip_in  = yaw[15] ^ yaw[14];
    assign phase_in = yaw ^ {flip_in, 15'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= pwt_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({{(W-32){phase_in[15]}}, phase_in, 16'b0});
            flip_reg[0] <= flip_in;
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        localparam logic [W-1:0] ATAN = {{(W-30){1'b0}}, pwt_pkg::atan_turn(g)};
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] x_next;
        logic signed [W-1:0] y_next;
        logic signed [W-1:0] z_next;

        always_comb
        begin
            dx = y_reg[g] >>> g;
            dy = x_reg[g] >>> g;
            if (!z_reg[g][W-1])
            begin
                x_next = x_reg[g] - dx;
                y_next = y_reg[g] + dy;
                z_next = z_reg[g] - $signed(ATAN);
            end
            else
            begin
                x_next = x_reg[g] + dx;
                y_next = y_reg[g] - dy;
                z_next = z_reg[g] + $signed(ATAN);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[g+1]    <= x_next;
                y_reg[g+1]    <= y_next;
                z_reg[g+1]    <= z_next;
                flip_reg[g+1] <= flip_reg[g];
            end
        end
    end

    always_comb
    begin
        x_fin = flip_reg[N] ? -x_reg[N] : x_reg[N];
        y_fin = flip_reg[N] ? -y_reg[N] : y_reg[N];
        if (x_fin > $signed({{(W-32){1'b0}}, pwt_pkg::ONE_Q30}))
            trig_next.cos_v = pwt_pkg::ONE_Q30;
        else if (x_fin < $signed({{(W-32){1'b1}}, pwt_pkg::NEG_ONE_Q30}))
            trig_next.cos_v = pwt_pkg::NEG_ONE_Q30;
        else
            trig_next.cos_v = x_fin[31:0];
        if (y_fin > $signed({{(W-32){1'b0}}, pwt_pkg::ONE_Q30}))
            trig_next.sin_v = pwt_pkg::ONE_Q30;
        else if (y_fin < $signed({{(W-32){1'b1}}, pwt_pkg::NEG_ONE_Q30}))
            trig_next.sin_v = pwt_pkg::NEG_ONE_Q30;
        else
            trig_next.sin_v = y_fin[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule

### rtl/pixel_to_world_transform.sv
// ----------------------------------------------------------------------------
// pixel_to_world_transform
// Bird-view pixel to world point: scale, row flip and origin offset into the
// car frame, rotation by car yaw minus a quarter turn, car position added,
// saturated to 32 bits.
// ----------------------------------------------------------------------------
// Accepts one item per clock while the output is not stalled and delivers one
// result per item, in order; the CORDIC array does one micro-rotation per
// stage. A stall on the output freezes the whole pipeline. Configuration
// writes are taken at once and must only be made while no item is in flight.
// ----------------------------------------------------------------------------
module pixel_to_world_transform #(
    parameter int ANGLE_BITS = pwt_pkg::ANGLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [15:0]                     pixel_x,
    input  logic [15:0]                     pixel_y,
    input  logic signed [31:0]              car_x,
    input  logic signed [31:0]              car_y,
    input  logic [15:0]                     car_yaw,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [31:0]              world_x,
    output logic signed [31:0]              world_y,
    output logic [15:0]                     world_yaw,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pwt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int N = (ANGLE_BITS < pwt_pkg::CORDIC_MAX) ? ANGLE_BITS
                                                          : pwt_pkg::CORDIC_MAX;
    localparam int L = N + 2;
    localparam int D = L + 3;

    logic [15:0]        mpp_reg;
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic [12:0]        height_reg;

    logic [D-1:0]       valid_reg;
    logic               adv;

    logic [15:0]        yaw_in;
    logic signed [17:0] dy_in;
    logic [31:0]        prodx_reg;
    logic signed [34:0] prody_reg;

    logic signed [32:0] cx_reg [1:L-1];
    logic signed [32:0] cy_reg [1:L-1];
    logic signed [31:0] carx_reg [0:L+1];
    logic signed [31:0] cary_reg [0:L+1];
    logic [15:0]        yaw_reg [0:L+2];

    logic signed [36:0] cx_sum;
    logic signed [36:0] cy_sum;

    pwt_pkg::trig_t     trig;

    logic signed [64:0] cx_ext;
    logic signed [64:0] cy_ext;
    logic signed [64:0] cos_ext;
    logic signed [64:0] sin_ext;
    logic signed [64:0] pxc_reg;
    logic signed [64:0] pys_reg;
    logic signed [64:0] pxs_reg;
    logic signed [64:0] pyc_reg;
    logic signed [65:0] rx_sum;
    logic signed [65:0] ry_sum;
    logic signed [35:0] rx_reg;
    logic signed [35:0] ry_reg;
    logic signed [36:0] wx_sum;
    logic signed [36:0] wy_sum;
    logic signed [31:0] world_x_reg;
    logic signed [31:0] world_y_reg;
    logic signed [31:0] world_x_next;
    logic signed [31:0] world_y_next;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -37'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpp_reg      <= pwt_pkg::MPP_RESET;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            height_reg   <= pwt_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pwt_pkg::REG_MPP:          mpp_reg      <= cfg_data[15:0];
                pwt_pkg::REG_ORIGIN_X:     origin_x_reg <= cfg_data;
                pwt_pkg::REG_ORIGIN_Y:     origin_y_reg <= cfg_data;
                pwt_pkg::REG_IMAGE_HEIGHT: height_reg   <= cfg_data[12:0];
                default:                   ;
            endcase
        end
    end

    // advance everything together; hold on a stalled result
    assign adv      = !valid_reg[D-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[D-2:0], in_valid};
    end

    assign yaw_in = car_yaw - pwt_pkg::QUARTER_TURN;
    assign dy_in  = $signed({1'b0, height_reg, 4'b0}) - $signed({2'b0, pixel_y});

    assign cx_sum = $signed({5'b0, prodx_reg}) + $signed({origin_x_reg[31], origin_x_reg, 4'b0})
                  + 37'sd8;
    assign cy_sum = $signed({{2{prody_reg[34]}}, prody_reg})
                  + $signed({origin_y_reg[31], origin_y_reg, 4'b0}) + 37'sd8;

    pwt_cordic #(
        .ITER (ANGLE_BITS)
    ) u_cordic (
        .clk  (clk),
        .adv  (adv),
        .yaw  (yaw_in),
        .trig (trig)
    );

    assign cx_ext  = $signed({{32{cx_reg[L-1][32]}}, cx_reg[L-1]});
    assign cy_ext  = $signed({{32{cy_reg[L-1][32]}}, cy_reg[L-1]});
    assign cos_ext = $signed({{33{trig.cos_v[31]}}, trig.cos_v});
    assign sin_ext = $signed({{33{trig.sin_v[31]}}, trig.sin_v});

    assign rx_sum = {pxc_reg[64], pxc_reg} - {pys_reg[64], pys_reg} + 66'sd536870912;
    assign ry_sum = {pxs_reg[64], pxs_reg} + {pyc_reg[64], pyc_reg} + 66'sd536870912;

    assign wx_sum = {rx_reg[35], rx_reg} + {{5{carx_reg[L+1][31]}}, carx_reg[L+1]};
    assign wy_sum = {ry_reg[35], ry_reg} + {{5{cary_reg[L+1][31]}}, cary_reg[L+1]};
    assign world_x_next = sat32(wx_sum);
    assign world_y_next = sat32(wy_sum);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prodx_reg   <= {16'b0, pixel_x} * {16'b0, mpp_reg};
            prody_reg   <= $signed({{17{dy_in[17]}}, dy_in}) * $signed({19'b0, mpp_reg});
            carx_reg[0] <= car_x;
            cary_reg[0] <= car_y;
            yaw_reg[0]  <= yaw_in;

            cx_reg[1] <= cx_sum[36:4];
            cy_reg[1] <= cy_sum[36:4];
            for (int k = 2; k <= L - 1; k++)
            begin
                cx_reg[k] <= cx_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
            end
            for (int k = 1; k <= L + 1; k++)
            begin
                carx_reg[k] <= carx_reg[k-1];
                cary_reg[k] <= cary_reg[k-1];
            end
            for (int k = 1; k <= L + 2; k++)
                yaw_reg[k] <= yaw_reg[k-1];

            pxc_reg <= cx_ext * cos_ext;
            pys_reg <= cy_ext * sin_ext;
            pxs_reg <= cx_ext * sin_ext;
            pyc_reg <= cy_ext * cos_ext;

            rx_reg <= rx_sum[65:30];
            ry_reg <= ry_sum[65:30];

            world_x_reg <= world_x_next;
            world_y_reg <= world_y_next;
        end
    end

    assign out_valid = valid_reg[D-1];
    assign world_x   = world_x_reg;
    assign world_y   = world_y_reg;
    assign world_yaw = yaw_reg[L+2];

`ifndef NO_ASSERTIONS
    // a stalled result freezes every stage
    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(valid_reg))
        else $error("pipeline moved while the result was stalled");

    // a result only appears behind an item in the last inner stage
    a_result_origin : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[D-2]))
        else $error("result appeared without an item behind it");

    // rotation terms stay within the unit range when they are used
    a_trig_range : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[L-1] |-> (trig.cos_v <= pwt_pkg::ONE_Q30
                            && trig.cos_v >= pwt_pkg::NEG_ONE_Q30
                            && trig.sin_v <= pwt_pkg::ONE_Q30
                            && trig.sin_v >= pwt_pkg::NEG_ONE_Q30))
        else $error("sine or cosine out of range");
`endif

endmodule
